@@ rtl/dqc_pkg.sv @@
// Shared types and constants for the double-ended queue checker.
// Depends on nothing; used by every module of the block.
`default_nettype none

package dqc_pkg;

	localparam int DEPTH = 1024;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int OP_W  = 2;
	localparam int OUT_W = 48;

	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd1;
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd2;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

	localparam logic [VAL_W-1:0] EMPTY_MARK = '1;

	typedef struct packed {
		logic take;
		logic load;
	} dqc_cmd_t;

endpackage

`default_nettype wire

@@ rtl/dqc_ctrl.sv @@
// Controller of the queue checker: request handshakes and sequencing.
// Depends on dqc_pkg; drives the command struct of dqc_dp.
`default_nettype none

module dqc_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output dqc_pkg::dqc_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_LOAD = 1'b1;

	logic state_q;
	logic m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE) && (!m_tvalid_q || m_tready);
	assign m_tvalid = m_tvalid_q;
	assign cmd.take = s_tvalid && s_tready;
	assign cmd.load = (state_q == ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.take) begin
						state_q <= ST_LOAD;
					end
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
					end
				end
				ST_LOAD: begin
					state_q    <= ST_IDLE;
					m_tvalid_q <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/dqc_dp.sv @@
// Datapath of the queue checker: element memory, pointers, count and result.
// Depends on dqc_pkg; sequenced by dqc_ctrl through the command struct.
`default_nettype none

module dqc_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dqc_pkg::dqc_cmd_t             cmd,
	input  wire logic [dqc_pkg::OP_W-1:0]      operation,
	input  wire logic signed [dqc_pkg::VAL_W-1:0] value,
	output logic [dqc_pkg::OUT_W-1:0]          result
);

	logic [dqc_pkg::VAL_W-1:0] mem [dqc_pkg::DEPTH];

	logic [dqc_pkg::IDX_W-1:0] head_q;
	logic [dqc_pkg::IDX_W-1:0] tail_q;
	logic [dqc_pkg::CNT_W-1:0] count_q;
	logic                      all_ok_q;

	logic [dqc_pkg::VAL_W-1:0] rd_q;
	logic [dqc_pkg::VAL_W-1:0] val_q;
	logic                      pop_q;
	logic                      empty_q;
	logic                      drop_q;

	logic [dqc_pkg::VAL_W-1:0] res_val_q;
	logic                      res_empty_q;
	logic                      res_mis_q;
	logic                      res_drop_q;
	logic [dqc_pkg::CNT_W-1:0] res_occ_q;

	logic [dqc_pkg::IDX_W-1:0] head_next;
	logic [dqc_pkg::IDX_W-1:0] head_prev;
	logic [dqc_pkg::IDX_W-1:0] tail_next;
	logic [dqc_pkg::IDX_W-1:0] tail_prev;
	logic                      is_pop;
	logic                      full;
	logic                      empty;
	logic                      wr_en;
	logic                      rd_en;
	logic [dqc_pkg::IDX_W-1:0] addr;
	logic [dqc_pkg::VAL_W-1:0] popped;
	logic                      mis;

	localparam logic [dqc_pkg::IDX_W-1:0] IDX_LAST = dqc_pkg::IDX_W'(dqc_pkg::DEPTH - 1);
	localparam logic [dqc_pkg::CNT_W-1:0] CNT_FULL = dqc_pkg::CNT_W'(dqc_pkg::DEPTH);

	assign head_next = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign tail_next = (tail_q == IDX_LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? IDX_LAST : tail_q - 1'b1;

	assign is_pop = operation[0];
	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign wr_en  = cmd.take && !is_pop && !full;
	assign rd_en  = cmd.take && is_pop && !empty;

	always_comb begin
		unique case (operation)
			dqc_pkg::OP_PUSH_FRONT: addr = head_prev;
			dqc_pkg::OP_POP_FRONT:  addr = head_q;
			dqc_pkg::OP_PUSH_BACK:  addr = tail_q;
			dqc_pkg::OP_POP_BACK:   addr = tail_prev;
			default:                addr = tail_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= value;
		end
		if (rd_en) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + 1'b1;
			if (operation == dqc_pkg::OP_PUSH_FRONT) begin
				head_q <= head_prev;
			end else begin
				tail_q <= tail_next;
			end
		end else if (rd_en) begin
			count_q <= count_q - 1'b1;
			if (operation == dqc_pkg::OP_POP_FRONT) begin
				head_q <= head_next;
			end else begin
				tail_q <= tail_prev;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			val_q   <= value;
			pop_q   <= is_pop;
			empty_q <= is_pop && empty;
			drop_q  <= !is_pop && full;
		end
	end

	assign popped = (pop_q && !empty_q) ? rd_q : dqc_pkg::EMPTY_MARK;
	assign mis    = pop_q && (popped != val_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_ok_q <= 1'b1;
		end else if (cmd.load && mis) begin
			all_ok_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_val_q   <= popped;
			res_empty_q <= empty_q;
			res_mis_q   <= mis;
			res_drop_q  <= drop_q;
			res_occ_q   <= count_q;
		end
	end

	assign result = {
		{(dqc_pkg::OUT_W - dqc_pkg::VAL_W - 4 - dqc_pkg::CNT_W){1'b0}},
		res_occ_q, res_drop_q, all_ok_q, res_mis_q, res_empty_q, res_val_q
	};

endmodule

`default_nettype wire

@@ rtl/double_ended_queue_checker.sv @@
// Top level of the double-ended queue checker.
// Depends on dqc_pkg, dqc_ctrl and dqc_dp.
//
// Input stream: each request is one deque operation, tuser selecting push front,
// pop front, push back or pop back, tdata carrying the value to push or the
// expected pop result (all ones expects an empty queue).
// Output stream: one result per request with the popped value, empty, mismatch,
// sticky all-matched and dropped-push flags, and the occupancy after the request.
// For each request the accept edge does the memory write or read and moves the
// pointers, and the next edge loads the output register from the registered
// memory read. A new request is not taken until the previous one has loaded its
// result, as the controller holds s_tready low in its load state.
// The next request is accepted while the previous result still waits, as long
// as the output register is empty or is being taken in that cycle; a stalled
// receiver holds tvalid and the result and stops further requests.
// Reset empties the queue and sets the all-matched flag; memory is not cleared.
`default_nettype none

module double_ended_queue_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] value
	input  wire logic [1:0]  s_tuser,  // [1:0] operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [31:0] popped_value, [32] was_empty, [33] mismatch, [34] all_matched,
	// [35] push_dropped, [46:36] occupancy, [47] zero
	output logic [47:0]      m_tdata
);

	dqc_pkg::dqc_cmd_t cmd;

	dqc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	dqc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.operation (s_tuser),
		.value     (s_tdata),
		.result    (m_tdata)
	);

endmodule

`default_nettype wire
